// ===== hw/rtl/ordered_timer_table_core_macros.svh =====
// assertion macros for the ordered timer table core
// no dependencies
`ifndef ORDERED_TIMER_TABLE_CORE_MACROS_SVH
`define ORDERED_TIMER_TABLE_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define OTT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define OTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/ott_pkg.sv =====
// shared types and constants for the ordered timer table core
// no dependencies
package ott_pkg;
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_REFRESH = 3'd2;
  localparam logic [2:0] CMD_RESET   = 3'd3;
  localparam logic [2:0] CMD_SCAN    = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [31:0] ROLLOVER_DEFAULT = 32'd3600000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot_id;
    logic [31:0] period_ms;
    logic        recurring;
    logic        restart_now;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  timer_id;
    logic [31:0] wait_ms;
    logic        front_changed;
    logic        last;
  } rsp_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;  // start a new walk
    logic step;   // consider the current slot
    logic cand;   // current slot is a candidate
  } cmp_ctl_t;
endpackage

// ===== hw/rtl/ordered_timer_table_core.sv =====
// ordered timer table core: sequencer, slot registers and one shared min/compare unit
// cancel/refresh need no walk; query, scan with nothing due, add/reset that place no timer: one walk
//   add/reset that place a timer walk a second time for the front check
// scan: one walk finds the due timers, then one walk per expired timer picks the earliest
// throughput: one request at a time, busy high until the last result strobe; no stalls
// reset (rst_ni low, async) frees all slots, clears previous time and notify flag
module ordered_timer_table_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ott_pkg::req_t       req_i,
  output logic                valid_o,
  output ott_pkg::rsp_t       rsp_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import ott_pkg::*;
  `include "ordered_timer_table_core_macros.svh"

  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CntW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(TIMER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_EVAL, S_SCANW, S_SCANE, S_OUT
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic [31:0] roll_win_q, prev_time_q;
  logic        notified_q;
  logic [TIMER_SLOTS-1:0] active_q, due_q, rearm_q;
  logic [31:0] dl_q  [TIMER_SLOTS];
  logic [31:0] per_q [TIMER_SLOTS];
  logic [CntW-1:0] cnt_q;
  // after the front check walk, this slot is compared with the earliest
  logic [IdxW-1:0] tgt_q;
  logic            fc_pend_q;
  rsp_t rsp_q;
  logic valid_q;

  // shared compare unit, candidate mux
  cmp_ctl_t        ctl;
  logic [IdxW-1:0] widx;
  logic            found;
  logic [IdxW-1:0] best_idx;
  logic [31:0]     best_dl;
  logic            in_walk;

  assign widx    = cnt_q[IdxW-1:0];
  assign in_walk = (state_q == S_WALK || state_q == S_SCANW) && cnt_q < LastCnt;
  assign ctl.clear = (state_q == S_IDLE) || (state_q == S_SCANE);
  assign ctl.step  = in_walk;
  assign ctl.cand  = (state_q == S_SCANW) ? due_q[widx] : active_q[widx];

  ott_min_unit #(.IdxW(IdxW)) u_min (
    .clk_i, .rst_ni, .ctl_i(ctl), .idx_i(widx), .dl_i(dl_q[widx]),
    .found_o(found), .best_idx_o(best_idx), .best_dl_o(best_dl)
  );

  // lowest free slot, found during the walk too (first inactive in ascending order)
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;

  logic sid_ok;
  logic [IdxW-1:0] sid;
  assign sid_ok = 32'(req_q.slot_id) < TIMER_SLOTS;
  assign sid    = IdxW'(req_q.slot_id);

  // large backward step of the clock: every timer expires on this scan
  logic scan_roll;
  assign scan_roll = (req_q.now_ms < prev_time_q) &&
                     ((prev_time_q - req_q.now_ms) > roll_win_q);

  function automatic rsp_t mk(logic [1:0] st, logic [3:0] id, logic [31:0] w,
                              logic fc, logic lst);
    rsp_t r;
    r.status = st; r.timer_id = id; r.wait_ms = w; r.front_changed = fc; r.last = lst;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      roll_win_q   <= ROLLOVER_DEFAULT;
      prev_time_q  <= '0;
      notified_q   <= 1'b0;
      active_q     <= '0;
      valid_q      <= 1'b0;
      cnt_q        <= '0;
      fc_pend_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) roll_win_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          cnt_q        <= '0;
          free_found_q <= 1'b0;
          fc_pend_q    <= 1'b0;
          if (start) begin
            req_q <= req_i;
            // cancel and refresh need no walk
            if (req_i.command == CMD_CANCEL || req_i.command == CMD_REFRESH)
              state_q <= S_OUT;
            else if (req_i.command == CMD_SCAN)
              state_q <= S_WALK;
            else
              state_q <= S_WALK;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
          if (req_q.command == CMD_CANCEL) begin
            if (sid_ok && active_q[sid]) begin
              active_q[sid] <= 1'b0;
              rsp_q <= mk(ST_OK, req_q.slot_id, '0, 1'b0, 1'b1);
            end else rsp_q <= mk(ST_FAIL, req_q.slot_id, '0, 1'b0, 1'b1);
          end else begin
            if (sid_ok && active_q[sid]) begin
              dl_q[sid] <= req_q.now_ms + per_q[sid];
              rsp_q <= mk(ST_OK, req_q.slot_id, '0, 1'b0, 1'b1);
            end else rsp_q <= mk(ST_FAIL, req_q.slot_id, '0, 1'b0, 1'b1);
          end
        end
        S_WALK: begin
          if (cnt_q < LastCnt) begin
            if (!free_found_q && !active_q[widx]) begin
              free_found_q <= 1'b1;
              free_idx_q   <= widx;
            end
            cnt_q <= cnt_q + CntW'(1);
          end else begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          // default: finish after this
          state_q <= S_IDLE;
          valid_q <= 1'b1;
          if (fc_pend_q) begin
            // second walk done: front check for target slot
            if (found && best_idx == tgt_q && !notified_q) begin
              notified_q <= 1'b1;
              rsp_q.front_changed <= 1'b1;
            end
          end else begin
            case (req_q.command)
              CMD_ADD: begin
                if (!free_found_q) rsp_q <= mk(ST_FAIL, '0, '0, 1'b0, 1'b1);
                else begin
                  active_q[free_idx_q] <= 1'b1;
                  per_q[free_idx_q]    <= req_q.period_ms;
                  dl_q[free_idx_q]     <= req_q.now_ms + req_q.period_ms;
                  rearm_q[free_idx_q]  <= req_q.recurring;
                  rsp_q <= mk(ST_OK, 4'(free_idx_q), '0, 1'b0, 1'b1);
                  tgt_q <= free_idx_q;
                  fc_pend_q <= 1'b1; valid_q <= 1'b0;
                  cnt_q <= '0; state_q <= S_SCANE;
                end
              end
              CMD_RESET: begin
                if (!sid_ok) rsp_q <= mk(ST_FAIL, req_q.slot_id, '0, 1'b0, 1'b1);
                else if (req_q.period_ms == per_q[sid] && !req_q.restart_now)
                  rsp_q <= mk(ST_OK, req_q.slot_id, '0, 1'b0, 1'b1);
                else if (!active_q[sid])
                  rsp_q <= mk(ST_FAIL, req_q.slot_id, '0, 1'b0, 1'b1);
                else begin
                  per_q[sid] <= req_q.period_ms;
                  dl_q[sid]  <= (req_q.restart_now ? req_q.now_ms
                                 : dl_q[sid] - per_q[sid]) + req_q.period_ms;
                  rsp_q <= mk(ST_OK, req_q.slot_id, '0, 1'b0, 1'b1);
                  tgt_q <= sid;
                  fc_pend_q <= 1'b1; valid_q <= 1'b0;
                  cnt_q <= '0; state_q <= S_SCANE;
                end
              end
              CMD_QUERY: begin
                notified_q <= 1'b0;
                if (!found) rsp_q <= mk(ST_OK, '0, ALL_ONES, 1'b0, 1'b1);
                else rsp_q <= mk(ST_OK, '0, (req_q.now_ms >= best_dl) ? '0
                                  : best_dl - req_q.now_ms, 1'b0, 1'b1);
              end
              CMD_SCAN: begin
                if (!found) rsp_q <= mk(ST_NONE, '0, '0, 1'b0, 1'b1);
                else begin
                  prev_time_q <= req_q.now_ms;
                  if (!scan_roll && best_dl > req_q.now_ms)
                    rsp_q <= mk(ST_NONE, '0, '0, 1'b0, 1'b1);
                  else begin
                    for (int i = 0; i < TIMER_SLOTS; i++)
                      due_q[i] <= active_q[i] && (scan_roll || dl_q[i] <= req_q.now_ms);
                    valid_q <= 1'b0;
                    cnt_q <= '0; state_q <= S_SCANE;
                  end
                end
              end
              default: rsp_q <= mk(ST_FAIL, '0, '0, 1'b0, 1'b1);
            endcase
          end
        end
        S_SCANE: begin
          // min unit cleared here; start next walk
          cnt_q   <= '0;
          state_q <= fc_pend_q ? S_WALK : S_SCANW;
        end
        S_SCANW: begin
          if (cnt_q < LastCnt) begin
            cnt_q <= cnt_q + CntW'(1);
          end else begin
            // emit the earliest due slot, then walk again if more slots are due
            due_q[best_idx] <= 1'b0;
            if (rearm_q[best_idx]) dl_q[best_idx] <= req_q.now_ms + per_q[best_idx];
            else active_q[best_idx] <= 1'b0;
            valid_q <= 1'b1;
            rsp_q <= mk(ST_OK, 4'(best_idx), '0, 1'b0,
                        $countones(due_q) == 1);
            state_q <= ($countones(due_q) == 1) ? S_IDLE : S_SCANE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `OTT_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, valid_q, state_q != S_WALK)
  `OTT_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, valid_q && rsp_q.last, state_q != S_SCANW)
  `OTT_ASSERT_IMP(a_idle_no_due, clk_i, rst_ni, state_q == S_SCANW, due_q != '0)
endmodule

// ===== hw/rtl/ott_min_unit.sv =====
// shared compare unit: tracks the earliest candidate slot over a walk
// depends on ott_pkg
module ott_min_unit #(
  parameter int IdxW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ott_pkg::cmp_ctl_t   ctl_i,
  input  logic [IdxW-1:0]     idx_i,
  input  logic [31:0]         dl_i,
  output logic                found_o,
  output logic [IdxW-1:0]     best_idx_o,
  output logic [31:0]         best_dl_o
);
  import ott_pkg::*;

  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     dl_q, dl_d;

  // slots are walked in ascending order, so strict less keeps the lower index on ties
  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    dl_d    = dl_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (ctl_i.step && ctl_i.cand && (!found_q || dl_i < dl_q)) begin
      found_d = 1'b1;
      idx_d   = idx_i;
      dl_d    = dl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    dl_q  <= dl_d;
  end

  assign found_o    = found_q;
  assign best_idx_o = idx_q;
  assign best_dl_o  = dl_q;
endmodule
